>>> design/idea_pkg.sv
// Shared types, constants and the modulo 65537 multiply for the IDEA cipher.
`default_nettype none
package idea_pkg;
   localparam int ROUNDS_DEF  = 8;
   localparam int WORD_W      = 16;
   localparam int BLOCK_W     = 64;
   localparam int KEY_W       = 64;
   localparam int KEY_FULL_W  = 128;
   localparam int ROT_STEP    = 25;
   localparam int WORDS_PER_ROT = 8;
   localparam int KEYS_PER_ROUND = 6;
   localparam int INV_STEPS   = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_KEY_HIGH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_LOW  = 2'd1;

   typedef logic [WORD_W-1:0] word_type;
   // word 3 is the first (most significant) word of the block
   typedef logic [3:0][WORD_W-1:0] block_type;
   typedef logic [KEYS_PER_ROUND-1:0][WORD_W-1:0] round_keys_type;
   typedef logic [3:0][WORD_W-1:0] final_keys_type;

   // multiply modulo 65537, a zero word stands for 65536
   function automatic word_type mulm(input word_type a, input word_type b);
      logic [2*WORD_W-1:0] p;
      word_type lo;
      word_type hi;
      word_type r;
      p  = a * b;
      lo = p[WORD_W-1:0];
      hi = p[2*WORD_W-1:WORD_W];
      if (a == '0) begin
         r = word_type'(1) - b;
      end else if (b == '0) begin
         r = word_type'(1) - a;
      end else begin
         r = lo - hi + {{(WORD_W-1){1'b0}}, (lo < hi)};
      end
      return r;
   endfunction
endpackage
`default_nettype wire

>>> design/idea_sched.sv
// Key registers, subkey expansion and the sequential inverse unit for decryption keys.
`default_nettype none
module idea_sched import idea_pkg::*; #(
   parameter int ROUNDS = ROUNDS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_valid,
   input  wire logic [CSR_INDEX_W-1:0]                csr_index,
   input  wire logic [KEY_W-1:0]                      csr_data,
   output logic                                       busy,
   output logic [KEYS_PER_ROUND*ROUNDS+3:0][WORD_W-1:0] enc_keys,
   output logic [KEYS_PER_ROUND*ROUNDS+3:0][WORD_W-1:0] dec_keys
);
   localparam int NK   = KEYS_PER_ROUND * ROUNDS + 4;
   localparam int NINV = 2 * ROUNDS + 2;
   localparam int IW   = $clog2(NINV);
   localparam int BW   = $clog2(INV_STEPS);
   localparam logic [IW-1:0] IDX_LAST = IW'(NINV - 1);
   localparam logic [BW-1:0] BIT_LAST = BW'(INV_STEPS - 1);

   logic [KEY_W-1:0] key_high_ff, key_high_in;
   logic [KEY_W-1:0] key_low_ff, key_low_in;
   logic             start_ff, start_in;
   logic             busy_ff, busy_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [BW-1:0]    bit_ff, bit_in;
   word_type         acc_ff, acc_in;
   word_type         base_ff, base_in;
   word_type         inv_ff [NINV];
   logic             inv_we;

   logic [KEY_FULL_W-1:0]          key_full;
   logic [NINV-1:0][WORD_W-1:0]    srcs;
   word_type                       mul_acc;
   word_type                       mul_sq;
   word_type                       src_next;
   logic [IW-1:0]                  idx_nxt;
   logic                           key_write;

   assign key_full  = {key_high_ff, key_low_ff};
   assign key_write = csr_valid &&
                      (csr_index == REG_KEY_HIGH || csr_index == REG_KEY_LOW);

   for (genvar i = 0; i < NK; i++) begin : g_enc
      localparam int ROT = (ROT_STEP * (i / WORDS_PER_ROT)) % KEY_FULL_W;
      localparam int POS = KEY_FULL_W - 1 - WORD_W * (i % WORDS_PER_ROT);
      logic [KEY_FULL_W-1:0] rot;
      if (ROT == 0) begin : g_plain
         assign rot = key_full;
      end else begin : g_rot
         assign rot = (key_full << ROT) | (key_full >> (KEY_FULL_W - ROT));
      end
      assign enc_keys[i] = rot[POS -: WORD_W];
   end

   for (genvar i = 0; i <= ROUNDS; i++) begin : g_dec
      localparam int D = KEYS_PER_ROUND * i;
      localparam int S = KEYS_PER_ROUND * (ROUNDS - i);
      assign srcs[2*i]     = enc_keys[S];
      assign srcs[2*i+1]   = enc_keys[S+3];
      assign dec_keys[D]   = inv_ff[2*i];
      assign dec_keys[D+3] = inv_ff[2*i+1];
      if (i == 0 || i == ROUNDS) begin : g_outer
         assign dec_keys[D+1] = word_type'(0) - enc_keys[S+1];
         assign dec_keys[D+2] = word_type'(0) - enc_keys[S+2];
      end else begin : g_inner
         assign dec_keys[D+1] = word_type'(0) - enc_keys[S+2];
         assign dec_keys[D+2] = word_type'(0) - enc_keys[S+1];
      end
      if (i < ROUNDS) begin : g_mix
         assign dec_keys[D+4] = enc_keys[S-2];
         assign dec_keys[D+5] = enc_keys[S-1];
      end
   end

   always_comb begin
      mul_acc  = mulm(acc_ff, base_ff);
      mul_sq   = mulm(base_ff, base_ff);
      idx_nxt  = idx_ff + 1'b1;
      src_next = (idx_ff == IDX_LAST) ? '0 : srcs[idx_nxt];
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      start_in = start_ff;
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      bit_in   = bit_ff;
      acc_in   = acc_ff;
      base_in  = base_ff;
      inv_we   = 1'b0;
      if (key_write) begin
         if (csr_index == REG_KEY_HIGH) begin
            key_high_in = csr_data;
         end else begin
            key_low_in = csr_data;
         end
         start_in = 1'b1;
         busy_in  = 1'b1;
      end else if (start_ff) begin
         start_in = 1'b0;
         idx_in   = '0;
         bit_in   = '0;
         acc_in   = word_type'(1);
         base_in  = srcs[0];
      end else if (busy_ff) begin
         acc_in  = mul_acc;
         base_in = mul_sq;
         bit_in  = bit_ff + 1'b1;
         if (bit_ff == BIT_LAST) begin
            inv_we  = 1'b1;
            acc_in  = word_type'(1);
            base_in = src_next;
            idx_in  = idx_nxt;
            if (idx_ff == IDX_LAST) begin
               busy_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         start_ff    <= 1'b1;
         busy_ff     <= 1'b1;
         idx_ff      <= '0;
         bit_ff      <= '0;
      end else begin
         key_high_ff <= key_high_in;
         key_low_ff  <= key_low_in;
         start_ff    <= start_in;
         busy_ff     <= busy_in;
         idx_ff      <= idx_in;
         bit_ff      <= bit_in;
      end
      acc_ff  <= acc_in;
      base_ff <= base_in;
      if (inv_we) begin
         inv_ff[idx_ff] <= mul_acc;
      end
   end

   assign busy = busy_ff;
endmodule
`default_nettype wire

>>> design/idea_round.sv
// One IDEA round cell: three pipeline stages split at each multiply.
`default_nettype none
module idea_round import idea_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  wire logic           in_mode,
   input  wire block_type      in_block,
   input  wire round_keys_type enc_key,
   input  wire round_keys_type dec_key,
   output logic                out_valid,
   input  wire logic           out_ready,
   output logic                out_mode,
   output block_type           out_block
);
   logic      v1_ff, v2_ff, v3_ff;
   logic      r1, r2, r3;
   logic      m1_ff, m2_ff, m3_ff;
   word_type  a1_ff, b1_ff, c1_ff, d1_ff;
   word_type  a1_in, b1_in, c1_in, d1_in;
   word_type  a2_ff, b2_ff, c2_ff, d2_ff, t2_ff, t2_in;
   block_type x3_ff, x3_in;
   round_keys_type k1, k2, k3;
   word_type  u, v;

   assign r3 = !v3_ff || out_ready;
   assign r2 = !v2_ff || r3;
   assign r1 = !v1_ff || r2;

   always_comb begin
      k1    = in_mode ? dec_key : enc_key;
      a1_in = mulm(in_block[3], k1[0]);
      b1_in = in_block[2] + k1[1];
      c1_in = in_block[1] + k1[2];
      d1_in = mulm(in_block[0], k1[3]);
      k2    = m1_ff ? dec_key : enc_key;
      t2_in = mulm(a1_ff ^ c1_ff, k2[4]);
      k3    = m2_ff ? dec_key : enc_key;
      u     = mulm((b2_ff ^ d2_ff) + t2_ff, k3[5]);
      v     = t2_ff + u;
      x3_in = {a2_ff ^ u, c2_ff ^ u, b2_ff ^ v, d2_ff ^ v};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= in_valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
      end
      if (r1) begin
         m1_ff <= in_mode;
         a1_ff <= a1_in;
         b1_ff <= b1_in;
         c1_ff <= c1_in;
         d1_ff <= d1_in;
      end
      if (r2) begin
         m2_ff <= m1_ff;
         a2_ff <= a1_ff;
         b2_ff <= b1_ff;
         c2_ff <= c1_ff;
         d2_ff <= d1_ff;
         t2_ff <= t2_in;
      end
      if (r3) begin
         m3_ff <= m2_ff;
         x3_ff <= x3_in;
      end
   end

   assign in_ready  = r1;
   assign out_valid = v3_ff;
   assign out_mode  = m3_ff;
   assign out_block = x3_ff;
endmodule
`default_nettype wire

>>> design/idea_final.sv
// Output transformation stage that also serves as the result register.
`default_nettype none
module idea_final import idea_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  wire logic           in_mode,
   input  wire block_type      in_block,
   input  wire final_keys_type enc_key,
   input  wire final_keys_type dec_key,
   output logic                out_valid,
   input  wire logic           out_ready,
   output block_type           out_block
);
   logic           v_ff;
   logic           rdy;
   block_type      y_ff, y_in;
   final_keys_type k;

   assign rdy = !v_ff || out_ready;

   always_comb begin
      k    = in_mode ? dec_key : enc_key;
      y_in = {mulm(in_block[3], k[0]), in_block[1] + k[1],
              in_block[2] + k[2], mulm(in_block[0], k[3])};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (rdy) begin
         v_ff <= in_valid;
      end
      if (rdy) begin
         y_ff <= y_in;
      end
   end

   assign in_ready  = rdy;
   assign out_valid = v_ff;
   assign out_block = y_ff;
endmodule
`default_nettype wire

>>> design/idea_block_cipher.sv
// IDEA block cipher top level: key schedule, chain of round cells, output stage.
//
//   channel  dir  handshake               payload
//   req      in   req_tvalid/req_tready   tdata data_block, tuser mode
//   rsp      out  rsp_tvalid/rsp_tready   tdata result_block
//   csr      in   csr_valid/csr_ready     csr_index, csr_data (key_high, key_low)
//
// One block per cycle while the key schedule is idle and rsp_tready is high; three
// stages per round cell, then the output stage. After reset and after each key write
// the inverse unit runs with req_tready low, one modular step per cycle.
// Each stage holds while the stage after it is full and stalled.
`default_nettype none
module idea_block_cipher import idea_pkg::*; #(
   parameter int ROUNDS = ROUNDS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [BLOCK_W-1:0]     req_tdata,   // [63:0] data_block
   input  wire logic                   req_tuser,   // [0] mode
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [BLOCK_W-1:0]          rsp_tdata,   // [63:0] result_block
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [KEY_W-1:0]       csr_data
);
   localparam int NK = KEYS_PER_ROUND * ROUNDS + 4;
   localparam int KF = KEYS_PER_ROUND * ROUNDS;

   logic                         busy;
   logic [NK-1:0][WORD_W-1:0]    enc_keys;
   logic [NK-1:0][WORD_W-1:0]    dec_keys;
   logic                         valid [ROUNDS+1];
   logic                         ready [ROUNDS+1];
   logic                         mode  [ROUNDS+1];
   block_type                    blk   [ROUNDS+1];
   block_type                    result;

   assign csr_ready = 1'b1;

   idea_sched #(.ROUNDS(ROUNDS)) u_sched (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .busy      (busy),
      .enc_keys  (enc_keys),
      .dec_keys  (dec_keys)
   );

   assign valid[0]   = req_tvalid && !busy;
   assign mode[0]    = req_tuser;
   assign blk[0]     = req_tdata;
   assign req_tready = ready[0] && !busy;

   for (genvar r = 0; r < ROUNDS; r++) begin : g_round
      idea_round u_round (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid[r]),
         .in_ready  (ready[r]),
         .in_mode   (mode[r]),
         .in_block  (blk[r]),
         .enc_key   (enc_keys[KEYS_PER_ROUND*r+5 : KEYS_PER_ROUND*r]),
         .dec_key   (dec_keys[KEYS_PER_ROUND*r+5 : KEYS_PER_ROUND*r]),
         .out_valid (valid[r+1]),
         .out_ready (ready[r+1]),
         .out_mode  (mode[r+1]),
         .out_block (blk[r+1])
      );
   end

   idea_final u_final (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid[ROUNDS]),
      .in_ready  (ready[ROUNDS]),
      .in_mode   (mode[ROUNDS]),
      .in_block  (blk[ROUNDS]),
      .enc_key   (enc_keys[KF+3 : KF]),
      .dec_key   (dec_keys[KF+3 : KF]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_block (result)
   );

   assign rsp_tdata = result;

   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready)
      else $error("transaction accepted while key schedule busy");

   a_write_restarts: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready &&
       (csr_index == REG_KEY_HIGH || csr_index == REG_KEY_LOW)) |=> busy)
      else $error("key write did not restart key schedule");

   a_reset_busy: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> busy)
      else $error("key schedule idle right after reset");

   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_tvalid)
      else $error("result valid right after reset");
endmodule
`default_nettype wire
